// ----- rtl/core/aabb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the affine box transform core.
// ----------------------------------------------------------------------------
package aabb_pkg;

    localparam int COORD_W   = 24;   // Q15.8
    localparam int COEF_W    = 24;   // Q7.16
    localparam int COEF_FRAC = 16;
    localparam int AXES      = 3;
    localparam int ROW_W     = 2;

    // Datapath widths
    localparam int PROD_W   = COORD_W + COEF_W + 1;        // |coef| * radius
    localparam int SUM_W    = PROD_W + 2;                  // three products
    localparam int SCALED_W = SUM_W - COEF_FRAC;
    localparam int OUT_W    = SCALED_W + 2;                // tc +/- h + t

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_BOX  = 1'b1
    } action_t;

    localparam logic [ROW_W-1:0] ROW_TRANS = 2'd3;

    localparam coef_t  COEF_ONE  = coef_t'(1 << COEF_FRAC);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Row write toward the coefficient store
    typedef struct packed {
        logic                             en;
        logic [ROW_W-1:0]                 row;
        logic [AXES-1:0][COORD_W-1:0]     data;
    } coef_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/aabb_coef_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_coef_store
// Holds the 3x3 coefficient matrix and the translation row; row writes.
// ----------------------------------------------------------------------------
module aabb_coef_store
    import aabb_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  coef_wr_t      wr_i,
    output coef_t         coef_o  [AXES][AXES],
    output coord_t        trans_o [AXES]
);

    coef_t  matrix_reg [AXES][AXES];
    coord_t trans_reg  [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < AXES; r++) begin
                trans_reg[r] <= '0;
                for (int c = 0; c < AXES; c++) begin
                    matrix_reg[r][c] <= (r == c) ? COEF_ONE : '0;
                end
            end
        end else if (wr_i.en) begin
            if (wr_i.row == ROW_TRANS) begin
                for (int c = 0; c < AXES; c++) begin
                    trans_reg[c] <= wr_i.data[c];
                end
            end else begin
                for (int c = 0; c < AXES; c++) begin
                    matrix_reg[wr_i.row][c] <= wr_i.data[c];
                end
            end
        end
    end

    assign coef_o  = matrix_reg;
    assign trans_o = trans_reg;

endmodule

`default_nettype wire

// ----- rtl/core/aabb_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_axis
// One output axis: column dot products for center and half-extent,
// rescale, translate and saturate.
// ----------------------------------------------------------------------------
module aabb_axis
    import aabb_pkg::*;
(
    input  coord_t center_i [AXES],
    input  coord_t radius_i [AXES],
    input  coef_t  coef_i   [AXES],
    input  coord_t trans_i,
    output coord_t min_o,
    output coord_t max_o,
    output logic   ovf_o
);

    logic signed [COEF_W:0]      mag    [AXES];
    logic signed [PROD_W-1:0]    prod_c [AXES];
    logic signed [PROD_W-1:0]    prod_h [AXES];
    logic signed [SUM_W-1:0]     sum_c;
    logic signed [SUM_W-1:0]     sum_h;
    logic signed [SCALED_W-1:0]  tc;
    logic signed [SCALED_W-1:0]  h;
    logic signed [OUT_W-1:0]     raw_min;
    logic signed [OUT_W-1:0]     raw_max;
    logic                        ovf_min;
    logic                        ovf_max;

    function automatic coord_t sat_coord(input logic signed [OUT_W-1:0] x);
        if (x > OUT_W'(COORD_MAX)) begin
            return COORD_MAX;
        end else if (x < OUT_W'(COORD_MIN)) begin
            return COORD_MIN;
        end
        return x[COORD_W-1:0];
    endfunction

    function automatic logic out_of_range(input logic signed [OUT_W-1:0] x);
        return (x > OUT_W'(COORD_MAX)) || (x < OUT_W'(COORD_MIN));
    endfunction

    always_comb begin
        sum_c = '0;
        sum_h = '0;
        for (int i = 0; i < AXES; i++) begin
            mag[i]    = coef_i[i][COEF_W-1] ? -((COEF_W+1)'(coef_i[i]))
                                            : (COEF_W+1)'(coef_i[i]);
            prod_c[i] = PROD_W'(center_i[i]) * PROD_W'(coef_i[i]);
            prod_h[i] = PROD_W'(mag[i]) * PROD_W'(radius_i[i]);
            sum_c     = sum_c + SUM_W'(prod_c[i]);
            sum_h     = sum_h + SUM_W'(prod_h[i]);
        end
    end

    // floor rescale to Q15.8
    assign tc = sum_c[SUM_W-1:COEF_FRAC];
    assign h  = sum_h[SUM_W-1:COEF_FRAC];

    assign raw_min = OUT_W'(tc) - OUT_W'(h) + OUT_W'(trans_i);
    assign raw_max = OUT_W'(tc) + OUT_W'(h) + OUT_W'(trans_i);

    assign min_o   = sat_coord(raw_min);
    assign max_o   = sat_coord(raw_max);
    assign ovf_min = out_of_range(raw_min);
    assign ovf_max = out_of_range(raw_max);
    assign ovf_o   = ovf_min | ovf_max;

endmodule

`default_nettype wire

// ----- rtl/core/aabb_affine_transform_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_affine_transform_core
// Affine transform of an axis-aligned box by a stored 3x3 matrix and a
// translation row; result is the enclosing box, saturated to Q15.8.
//
// Path: a box transferred into the input register moves on to the result
//   register once that register is empty or its result is taken.
// Throughput: one item per cycle unless the result port stalls;
//   one combinational pass of 18 multipliers sits between the two registers.
// Loads write a matrix or translation row as they leave the input register and give no result.
// Reset: identity matrix, zero translation, both registers empty.
// ----------------------------------------------------------------------------
module aabb_affine_transform_core
    import aabb_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_action,
    input  wire logic [ROW_W-1:0]    s_row_index,
    input  wire logic signed [COORD_W-1:0] s_val_a,
    input  wire logic signed [COORD_W-1:0] s_val_b,
    input  wire logic signed [COORD_W-1:0] s_val_c,
    input  wire logic signed [COORD_W-1:0] s_box_max_x,
    input  wire logic signed [COORD_W-1:0] s_box_max_y,
    input  wire logic signed [COORD_W-1:0] s_box_max_z,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [COORD_W-1:0] m_out_min_x,
    output logic signed [COORD_W-1:0] m_out_min_y,
    output logic signed [COORD_W-1:0] m_out_min_z,
    output logic signed [COORD_W-1:0] m_out_max_x,
    output logic signed [COORD_W-1:0] m_out_max_y,
    output logic signed [COORD_W-1:0] m_out_max_z,
    output logic                     m_overflow
);

    // Input register
    logic             s1_valid_reg;
    logic             s1_valid_next;
    action_t          s1_action_reg;
    logic [ROW_W-1:0] s1_row_reg;
    coord_t           s1_lo_reg [AXES];
    coord_t           s1_hi_reg [AXES];

    // Result register
    logic             m_valid_reg;
    logic             m_valid_next;
    coord_t           out_min_reg [AXES];
    coord_t           out_max_reg [AXES];
    logic             overflow_reg;

    logic             s_xfer;
    logic             s1_is_box;
    logic             s1_adv;
    logic             box_adv;

    coef_wr_t         coef_wr;
    coef_t            coef_w  [AXES][AXES];
    coef_t            col_w   [AXES][AXES];
    coord_t           trans_w [AXES];

    coord_t           center_w [AXES];
    coord_t           radius_w [AXES];
    logic signed [COORD_W:0] pair_sum  [AXES];
    logic signed [COORD_W:0] pair_diff [AXES];

    coord_t           min_w [AXES];
    coord_t           max_w [AXES];
    logic [AXES-1:0]  ovf_w;

    // ---- handshake ----
    assign s1_is_box = (s1_action_reg == ACT_BOX);
    assign box_adv   = s1_valid_reg && s1_is_box && (!m_valid_reg || m_ready);
    assign s1_adv    = (s1_valid_reg && !s1_is_box) || box_adv;
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s_xfer    = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_xfer) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (box_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_action_reg <= action_t'(s_action);
            s1_row_reg    <= s_row_index;
            s1_lo_reg[0]  <= s_val_a;
            s1_lo_reg[1]  <= s_val_b;
            s1_lo_reg[2]  <= s_val_c;
            s1_hi_reg[0]  <= s_box_max_x;
            s1_hi_reg[1]  <= s_box_max_y;
            s1_hi_reg[2]  <= s_box_max_z;
        end
    end

    // ---- coefficient store ----
    always_comb begin
        coef_wr.en  = s1_valid_reg && !s1_is_box;
        coef_wr.row = s1_row_reg;
        for (int i = 0; i < AXES; i++) begin
            coef_wr.data[i] = s1_lo_reg[i];
        end
    end

    aabb_coef_store u_coef_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_i    (coef_wr),
        .coef_o  (coef_w),
        .trans_o (trans_w)
    );

    // column j of the matrix feeds output axis j
    always_comb begin
        for (int j = 0; j < AXES; j++) begin
            for (int i = 0; i < AXES; i++) begin
                col_w[j][i] = coef_w[i][j];
            end
        end
    end

    // ---- center and radius, floor halving ----
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            pair_sum[i]  = (COORD_W+1)'(s1_hi_reg[i]) + (COORD_W+1)'(s1_lo_reg[i]);
            pair_diff[i] = (COORD_W+1)'(s1_hi_reg[i]) - (COORD_W+1)'(s1_lo_reg[i]);
            center_w[i]  = pair_sum[i][COORD_W:1];
            radius_w[i]  = pair_diff[i][COORD_W:1];
        end
    end

    for (genvar j = 0; j < AXES; j++) begin : g_axis
        aabb_axis u_axis (
            .center_i (center_w),
            .radius_i (radius_w),
            .coef_i   (col_w[j]),
            .trans_i  (trans_w[j]),
            .min_o    (min_w[j]),
            .max_o    (max_w[j]),
            .ovf_o    (ovf_w[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (box_adv) begin
            out_min_reg  <= min_w;
            out_max_reg  <= max_w;
            overflow_reg <= |ovf_w;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_min_x = out_min_reg[0];
    assign m_out_min_y = out_min_reg[1];
    assign m_out_min_z = out_min_reg[2];
    assign m_out_max_x = out_max_reg[0];
    assign m_out_max_y = out_max_reg[1];
    assign m_out_max_z = out_max_reg[2];
    assign m_overflow  = overflow_reg;

    // ---- assertions ----
    a_result_from_box : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(box_adv))
        else $error("result appeared without a box leaving the input register");

    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !box_adv)
        else $error("stalled result overwritten");

    a_load_drains : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_is_box) |-> s_ready)
        else $error("load held in input register");

    a_trans_write : assert property (@(posedge aclk) disable iff (!aresetn)
        (coef_wr.en && coef_wr.row == ROW_TRANS) |=>
            (trans_w[0] == $past(s1_lo_reg[0])))
        else $error("translation row not written");

endmodule

`default_nettype wire
